// File: hdl/pwbc_pkg.sv
// shared types and constants for the position weighted bit checksum
// no dependencies
package pwbc_pkg;

	localparam int DATA_W    = 8;
	localparam int SUM_W     = 32;
	localparam int POS_W     = 32;
	localparam int SUM_COUNT = 9;
	localparam int NUM_W     = 4;
	localparam int TDATA_W   = 40;

	localparam logic [NUM_W-1:0] LAST_NUM = NUM_W'(SUM_COUNT - 1);

	typedef logic [SUM_COUNT-1:0][SUM_W-1:0] sums_t;

	typedef struct packed {
		logic  load;
		sums_t sums;
	} snap_load_t;

endpackage

// File: hdl/position_weighted_bit_checksum.sv
// top level of the position weighted bit checksum
// depends on pwbc_pkg, pwbc_accum, pwbc_drain
//
// the slave channel takes one image byte per item, tlast on the final byte
// of an image. a byte sum and eight position sums (bits 7 down to 0) are
// kept modulo 2^32 against a zero-based byte position.
// after the last byte the master channel gives nine items, word 0 the byte
// sum and words 1..8 the bit sums, tlast on the ninth.
// throughput is one byte per cycle, set by the single register stage of
// nine parallel adders. the first word appears once the last byte has
// left the input register, then one word per cycle while tready is high.
// bytes of the next image are taken while words drain; a last byte waits
// in the input register until the previous run of nine has left.
// a master stall holds the current word and lets bytes continue until
// that wait. reset clears the position, the sums and both channels.
module position_weighted_bit_checksum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pwbc_pkg::DATA_W-1:0]   s_tdata,  // data_byte
	input  logic                          s_tlast,  // end_of_image
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pwbc_pkg::TDATA_W-1:0]  m_tdata,  // check_word, word_number
	output logic                          m_tlast   // final_word
);

	pwbc_pkg::snap_load_t        snap_ld;
	logic                        snap_busy;

	pwbc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.snap_busy (snap_busy),
		.snap_ld   (snap_ld)
	);

	pwbc_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_ld   (snap_ld),
		.snap_busy (snap_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// File: hdl/pwbc_accum.sv
// input register, byte position counter and the nine running sums
// depends on pwbc_pkg
module pwbc_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pwbc_pkg::DATA_W-1:0]   s_tdata,  // data_byte
	input  logic                          s_tlast,  // end_of_image
	input  logic                          snap_busy,
	output pwbc_pkg::snap_load_t          snap_ld
);

	logic                        v_s1;
	logic                        last_s1;
	logic [pwbc_pkg::DATA_W-1:0] byte_s1;
	logic [pwbc_pkg::POS_W-1:0]  pos_q;
	pwbc_pkg::sums_t             sums_q;
	pwbc_pkg::sums_t             sums_nxt;
	logic                        adv;

	always_comb begin
		sums_nxt[0] = sums_q[0] + pwbc_pkg::SUM_W'(byte_s1);
		for (int k = 1; k < pwbc_pkg::SUM_COUNT; k++) begin
			sums_nxt[k] = sums_q[k] + (byte_s1[pwbc_pkg::SUM_COUNT-1-k] ? pos_q : '0);
		end
	end

	// a last item waits while the previous run is still draining
	assign adv      = v_s1 && !(last_s1 && snap_busy);
	assign s_tready = !v_s1 || adv;

	assign snap_ld.load = adv && last_s1;
	assign snap_ld.sums = sums_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			pos_q  <= '0;
			sums_q <= '0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				if (last_s1) begin
					pos_q  <= '0;
					sums_q <= '0;
				end else begin
					pos_q  <= pos_q + 1'b1;
					sums_q <= sums_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

// File: hdl/pwbc_drain.sv
// snapshot of the finished sums, shifted out one word per item
// depends on pwbc_pkg
module pwbc_drain (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pwbc_pkg::snap_load_t           snap_ld,
	output logic                           snap_busy,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pwbc_pkg::TDATA_W-1:0]   m_tdata,
	output logic                           m_tlast
);

	pwbc_pkg::sums_t              snap_q;
	logic [pwbc_pkg::NUM_W-1:0]   idx_q;
	logic                         active_q;

	assign snap_busy = active_q;
	assign m_tvalid  = active_q;
	assign m_tlast   = (idx_q == pwbc_pkg::LAST_NUM);
	assign m_tdata   = {{(pwbc_pkg::TDATA_W - pwbc_pkg::SUM_W - pwbc_pkg::NUM_W){1'b0}},
		idx_q, snap_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (snap_ld.load) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q && m_tready) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == pwbc_pkg::LAST_NUM) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ld.load) begin
			snap_q <= snap_ld.sums;
		end else if (active_q && m_tready) begin
			snap_q <= {{pwbc_pkg::SUM_W{1'b0}}, snap_q[pwbc_pkg::SUM_COUNT-1:1]};
		end
	end

endmodule

// File: verif/pwbc_checker.sv
`timescale 1ns / 1ps
// checker for position_weighted_bit_checksum: folds every accepted byte into its own
// position counter and nine sums, queues the nine words of each image, compares words
// depends on pwbc_pkg
module pwbc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [pwbc_pkg::DATA_W-1:0]   s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [pwbc_pkg::TDATA_W-1:0]  m_tdata,
	input  logic                          m_tlast,
	output int                            errors,
	output int                            pending,
	output int                            bytes_seen,
	output int                            images_seen,
	output int                            words_seen
);

	typedef struct {
		logic [pwbc_pkg::SUM_W-1:0] word;
		logic [pwbc_pkg::NUM_W-1:0] num;
		logic                       fin;
	} sum_word_t;

	logic [pwbc_pkg::POS_W-1:0] position;
	logic [pwbc_pkg::SUM_W-1:0] sums [pwbc_pkg::SUM_COUNT];
	sum_word_t                  sum_words_due [$];
	int                         n_err    = 0;
	int                         n_bytes  = 0;
	int                         n_images = 0;
	int                         n_words  = 0;

	task automatic fold_byte(input logic [pwbc_pkg::DATA_W-1:0] b, input logic last);
		sum_word_t w;
		n_bytes++;
		sums[0] += pwbc_pkg::SUM_W'(b);
		for (int k = 1; k < pwbc_pkg::SUM_COUNT; k++) begin
			if (b[pwbc_pkg::DATA_W - k])
				sums[k] += position;
		end
		position += 1'b1;
		if (last) begin
			for (int k = 0; k < pwbc_pkg::SUM_COUNT; k++) begin
				w.word = sums[k];
				w.num  = pwbc_pkg::NUM_W'(k);
				w.fin  = (w.num == pwbc_pkg::LAST_NUM);
				sum_words_due.push_back(w);
				sums[k] = '0;
			end
			position = '0;
			n_images++;
		end
	endtask

	task automatic check_sum_word(input logic [pwbc_pkg::TDATA_W-1:0] d, input logic last);
		sum_word_t w;
		n_words++;
		if (sum_words_due.size() == 0) begin
			n_err++;
			if (n_err <= 10)
				$display("unexpected word: sum %h num %0d tlast %b",
					d[pwbc_pkg::SUM_W-1:0],
					d[pwbc_pkg::SUM_W+pwbc_pkg::NUM_W-1:pwbc_pkg::SUM_W], last);
		end else begin
			w = sum_words_due.pop_front();
			if (d[pwbc_pkg::SUM_W-1:0] !== w.word
					|| d[pwbc_pkg::SUM_W+pwbc_pkg::NUM_W-1:pwbc_pkg::SUM_W] !== w.num
					|| last !== w.fin) begin
				n_err++;
				if (n_err <= 10)
					$display({"word mismatch: expected sum %h num %0d tlast %b, ",
						"got sum %h num %0d tlast %b"},
						w.word, w.num, w.fin,
						d[pwbc_pkg::SUM_W-1:0],
						d[pwbc_pkg::SUM_W+pwbc_pkg::NUM_W-1:pwbc_pkg::SUM_W], last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position = '0;
			for (int k = 0; k < pwbc_pkg::SUM_COUNT; k++)
				sums[k] = '0;
			sum_words_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				fold_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_sum_word(m_tdata, m_tlast);
		end
		errors      <= n_err;
		pending     <= sum_words_due.size();
		bytes_seen  <= n_bytes;
		images_seen <= n_images;
		words_seen  <= n_words;
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// top of the position_weighted_bit_checksum testbench: clock, reset, byte stimulus,
// master back pressure, watchdog and verdict; checking lives in pwbc_checker
// depends on pwbc_pkg, pwbc_checker and the block itself
module tb_top;

	localparam int N_BYTES    = 220;
	localparam int IDLE_LIMIT = 2000;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [pwbc_pkg::DATA_W-1:0]  s_tdata  = '0;
	logic                         s_tlast  = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [pwbc_pkg::TDATA_W-1:0] m_tdata;
	logic                         m_tlast;

	int errors;
	int pending;
	int bytes_seen;
	int images_seen;
	int words_seen;

	int          burst_left  = 0;
	bit          steady      = 1'b0;
	logic [31:0] ready_pattern = '1;
	logic [4:0]  stall_phase = '0;
	int          stall_round = 0;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	position_weighted_bit_checksum DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	pwbc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.pending     (pending),
		.bytes_seen  (bytes_seen),
		.images_seen (images_seen),
		.words_seen  (words_seen)
	);

	// master stalls: a new 32-bit ready pattern each round, every fourth one stall free
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_round++;
			case (stall_round % 4)
				0:       ready_pattern = '1;
				1:       ready_pattern = $urandom;
				2:       ready_pattern = $urandom | $urandom;
				default: ready_pattern = $urandom & $urandom;
			endcase
		end
		m_tready <= ready_pattern[stall_phase];
		stall_phase = stall_phase + 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
			$display("[position_weighted_bit_checksum] ERROR");
			$finish;
		end
	end

	// one byte, preceded by a random gap (none when steady) whenever a burst runs out
	task automatic push_byte(input logic [pwbc_pkg::DATA_W-1:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 9);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_image(input int len);
		logic [pwbc_pkg::DATA_W-1:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0:       b = '0;
				1:       b = '1;
				2:       b = pwbc_pkg::DATA_W'(1) << $urandom_range(0, pwbc_pkg::DATA_W - 1);
				default: b = pwbc_pkg::DATA_W'($urandom);
			endcase
			push_byte(b, i == len - 1);
		end
	endtask

	initial begin
		int sent;
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte images, all ones and all zeros
		push_byte(8'hff, 1'b1);
		push_byte(8'h00, 1'b1);
		// walking one from bit 7 down, then the extremes
		for (int k = 0; k < pwbc_pkg::DATA_W; k++)
			push_byte(8'h80 >> k, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'haa, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hff, 1'b1);
		// back-to-back single-byte images while words drain
		steady = 1'b1;
		push_byte(8'h01, 1'b1);
		push_byte(8'h80, 1'b1);
		sent = 17;

		while (sent < N_BYTES) begin
			steady = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
			if (len > N_BYTES - sent)
				len = N_BYTES - sent;
			send_image(len);
			sent += len;
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d bytes in %0d images, %0d check words compared",
			bytes_seen, images_seen, words_seen);
		$display("directed single-byte and walking-bit images, then random images up to 60 bytes");
		if (errors == 0 && pending == 0) begin
			$display("[position_weighted_bit_checksum] OK");
		end else begin
			$display("%0d failures", errors);
			$display("[position_weighted_bit_checksum] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/pwbc_pkg.sv
hdl/pwbc_accum.sv
hdl/pwbc_drain.sv
hdl/position_weighted_bit_checksum.sv
verif/pwbc_checker.sv
verif/tb_top.sv
